// File: rtl/core/postfix_expression_evaluator_macros.svh
// Assertion macros for the postfix expression evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// same-cycle implication
`define PEV_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PEV_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pev_pkg.sv
// Shared types and constants of the postfix expression evaluator
package pev_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam int CMDQ_DEPTH  = 4;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   localparam int DATA_W      = 32;
   localparam int DIV_STEPS   = DATA_W;
   localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_FIN  = 3'd5;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       finish;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic                     underflow_seen;
      logic                     overflow_seen;
      logic                     divide_by_zero_seen;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] val;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

endpackage

// File: rtl/core/pev_front.sv
// Front end: accepts requests and decodes characters into stack commands
module pev_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pev_pkg::req_type      req_data,
   input  logic                  cmdq_full,
   output pev_pkg::cmd_push_type cmdq_push
);

   logic             keep;
   pev_pkg::cmd_type cmd;
   logic [7:0]       digit;

   assign digit = req_data.ch - pev_pkg::CH_ZERO;

   always_comb begin
      keep    = 1'b0;
      cmd.op  = pev_pkg::OP_PUSH;
      cmd.val = digit[3:0];
      if (req_data.finish) begin
         keep   = 1'b1;
         cmd.op = pev_pkg::OP_FIN;
      end else begin
         unique case (req_data.ch) inside
            [pev_pkg::CH_ZERO:pev_pkg::CH_NINE]: begin
               keep   = 1'b1;
               cmd.op = pev_pkg::OP_PUSH;
            end
            pev_pkg::CH_PLUS: begin
               keep   = 1'b1;
               cmd.op = pev_pkg::OP_ADD;
            end
            pev_pkg::CH_MINUS: begin
               keep   = 1'b1;
               cmd.op = pev_pkg::OP_SUB;
            end
            pev_pkg::CH_STAR: begin
               keep   = 1'b1;
               cmd.op = pev_pkg::OP_MUL;
            end
            pev_pkg::CH_SLASH: begin
               keep   = 1'b1;
               cmd.op = pev_pkg::OP_DIV;
            end
            default: keep = 1'b0;
         endcase
      end
   end

   assign req_stall       = cmdq_full;
   assign cmdq_push.valid = req_valid & ~cmdq_full & keep;
   assign cmdq_push.cmd   = cmd;

endmodule

// File: rtl/core/pev_cmdq.sv
// Command queue between front end and stack engine
module pev_cmdq (
   input  logic                  clock,
   input  logic                  reset,
   input  pev_pkg::cmd_push_type push,
   output logic                  full,
   output logic                  cmd_valid,
   output pev_pkg::cmd_type      cmd,
   input  logic                  cmd_pop
);

   localparam logic [pev_pkg::CMDQ_PTR_W-1:0] LAST_PTR =
      pev_pkg::CMDQ_PTR_W'(pev_pkg::CMDQ_DEPTH - 1);

   pev_pkg::cmd_type                q_ff [pev_pkg::CMDQ_DEPTH];
   logic [pev_pkg::CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pev_pkg::CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pev_pkg::CMDQ_CNT_W-1:0]  fill_ff, fill_in;
   logic                            do_push, do_pop;

   assign full      = (fill_ff == pev_pkg::CMDQ_CNT_W'(pev_pkg::CMDQ_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push.valid & ~full;
   assign do_pop    = cmd_pop & cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// File: rtl/core/pev_back.sv
// Stack engine: operand stack, arithmetic, iterative divider, result register
module pev_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  pev_pkg::cmd_type      cmd,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pev_pkg::rsp_type      rsp_data,
   output pev_pkg::cnt_type      stack_count
);

   localparam int DW = pev_pkg::DATA_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POP2 = 3'd1;
   localparam logic [2:0] S_OPER = 3'd2;
   localparam logic [2:0] S_CALC = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_DFIX = 3'd5;
   localparam logic [2:0] S_PUSH = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   localparam pev_pkg::cnt_type FULL_CNT = pev_pkg::CNT_W'(pev_pkg::STACK_DEPTH);
   localparam logic [pev_pkg::DIV_STEP_W-1:0] LAST_STEP =
      pev_pkg::DIV_STEP_W'(pev_pkg::DIV_STEPS - 1);

   logic [DW-1:0]                   stack_ff [pev_pkg::STACK_DEPTH];
   logic [DW-1:0]                   rdata_ff;

   logic [2:0]                      state_ff, state_in;
   pev_pkg::cnt_type                count_ff, count_in, cnt_m1;
   logic                            unf_ff, unf_in;
   logic                            ovf_ff, ovf_in;
   logic                            dz_ff, dz_in;
   logic [2:0]                      op_ff, op_in;
   logic                            rd_mem_ff, rd_mem_in;
   logic [DW-1:0]                   rhs_ff, rhs_in;
   logic [DW-1:0]                   lhs_ff, lhs_in;
   logic [DW-1:0]                   res_ff, res_in;
   logic [DW-1:0]                   dvd_ff, dvd_in;
   logic [DW-1:0]                   dvs_ff, dvs_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic                            neg_ff, neg_in;
   logic [pev_pkg::DIV_STEP_W-1:0]  step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pev_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                            pop_req;
   logic                            rd_en, wr_en;
   logic [pev_pkg::PTR_W-1:0]       rd_addr, wr_addr;
   logic [DW:0]                     trial, diff;
   logic [DW-1:0]                   popped;

   assign cnt_m1  = count_ff - 1'b1;
   assign rd_addr = cnt_m1[pev_pkg::PTR_W-1:0];
   assign wr_addr = count_ff[pev_pkg::PTR_W-1:0];
   assign popped  = rd_mem_ff ? rdata_ff : '1;
   assign trial   = {rem_ff, dvd_ff[DW-1]};
   assign diff    = trial - {1'b0, dvs_ff};

   assign cmd_pop     = (state_ff == S_IDLE) & cmd_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign stack_count = count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      unf_in       = unf_ff;
      ovf_in       = ovf_ff;
      dz_in        = dz_ff;
      op_in        = op_ff;
      rd_mem_in    = rd_mem_ff;
      rhs_in       = rhs_ff;
      lhs_in       = lhs_ff;
      res_in       = res_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop_req      = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               op_in = cmd.op;
               if (cmd.op == pev_pkg::OP_PUSH) begin
                  res_in   = DW'(cmd.val);
                  state_in = S_PUSH;
               end else if (cmd.op == pev_pkg::OP_FIN) begin
                  pop_req  = 1'b1;
                  state_in = S_FIN;
               end else begin
                  pop_req  = 1'b1;
                  state_in = S_POP2;
               end
            end
         end
         S_POP2: begin
            rhs_in   = popped;
            pop_req  = 1'b1;
            state_in = S_OPER;
         end
         S_OPER: begin
            lhs_in   = popped;
            state_in = S_CALC;
         end
         S_CALC: begin
            state_in = S_PUSH;
            unique case (op_ff)
               pev_pkg::OP_ADD: res_in = lhs_ff + rhs_ff;
               pev_pkg::OP_SUB: res_in = lhs_ff - rhs_ff;
               pev_pkg::OP_MUL: res_in = lhs_ff * rhs_ff;
               pev_pkg::OP_DIV: begin
                  if (rhs_ff == '0) begin
                     res_in = '0;
                     dz_in  = 1'b1;
                  end else begin
                     dvd_in   = lhs_ff[DW-1] ? -lhs_ff : lhs_ff;
                     dvs_in   = rhs_ff[DW-1] ? -rhs_ff : rhs_ff;
                     rem_in   = '0;
                     step_in  = '0;
                     neg_in   = lhs_ff[DW-1] ^ rhs_ff[DW-1];
                     state_in = S_DIV;
                  end
               end
               default: res_in = lhs_ff;
            endcase
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (!diff[DW]) begin
               rem_in = diff[DW-1:0];
               dvd_in = {dvd_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = trial[DW-1:0];
               dvd_in = {dvd_ff[DW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_DFIX;
            end
         end
         S_DFIX: begin
            res_in   = neg_ff ? -dvd_ff : dvd_ff;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (count_ff == FULL_CNT) begin
               ovf_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
            state_in = S_IDLE;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.result_value        = popped;
               rsp_data_in.underflow_seen      = unf_ff;
               rsp_data_in.overflow_seen       = ovf_ff;
               rsp_data_in.divide_by_zero_seen = dz_ff;
               count_in                        = '0;
               unf_in                          = 1'b0;
               ovf_in                          = 1'b0;
               dz_in                           = 1'b0;
               state_in                        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // shared pop: empty stack yields all ones
      if (pop_req) begin
         if (count_ff == '0) begin
            unf_in    = 1'b1;
            rd_mem_in = 1'b0;
         end else begin
            rd_en     = 1'b1;
            rd_mem_in = 1'b1;
            count_in  = cnt_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         unf_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         dz_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         unf_ff       <= unf_in;
         ovf_ff       <= ovf_in;
         dz_ff        <= dz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rd_mem_ff   <= rd_mem_in;
      rhs_ff      <= rhs_in;
      lhs_ff      <= lhs_in;
      res_ff      <= res_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= res_ff;
      end
      if (rd_en) begin
         rdata_ff <= stack_ff[rd_addr];
      end
   end

endmodule

// File: rtl/core/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator
//
//   channel  ports                               dir  moves
//   req      req_valid  req_stall  req_data      in   one character or terminator
//   rsp      rsp_valid  rsp_stall  rsp_data      out  final value and error flags
//
// Engine states per request: digit PUSH; + - * POP2, OPER, CALC, PUSH; / on a nonzero
// divisor adds DIV (32-step divider), DFIX; terminator FIN; front end drops others.
// A 4-entry command queue lets the front end take requests while the engine works.
// Synchronous active-high reset clears control state; the operand stack is not cleared.
// rsp_stall holds the engine at a terminator until the result register is free.
module postfix_expression_evaluator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pev_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pev_pkg::rsp_type rsp_data
);

`include "postfix_expression_evaluator_macros.svh"

   localparam pev_pkg::cnt_type FULL_CNT = pev_pkg::CNT_W'(pev_pkg::STACK_DEPTH);

   pev_pkg::cmd_push_type cmdq_push;
   logic                  cmdq_full;
   logic                  cmd_valid;
   pev_pkg::cmd_type      cmd;
   logic                  cmd_pop;
   pev_pkg::cnt_type      stack_count;

   pev_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmdq_full (cmdq_full),
      .cmdq_push (cmdq_push)
   );

   pev_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmdq_push),
      .full      (cmdq_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   pev_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .stack_count (stack_count)
   );

   `PEV_CHECK(a_push_not_full, cmdq_push.valid, !cmdq_full, "push into full command queue")
   `PEV_CHECK(a_count_bound, 1'b1, stack_count <= FULL_CNT, "stack count past depth")
   `PEV_CHECK(a_fin_clears, $rose(rsp_valid), stack_count == '0, "stack not cleared at result")
   `PEV_CHECK_NEXT(a_pop_valid, cmd_pop && !cmd_valid, 1'b0, "command popped from empty queue")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the postfix expression evaluator
module tb_top;
   import pev_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 6;
   localparam int ITEM_TARGET    = 1400;
   localparam int QUIET_ITEMS    = 150;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 500;
   localparam int DRAIN_CYCLES   = 200;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   class postfix_tracker;
      logic [DATA_W-1:0] operands [STACK_DEPTH];
      int unsigned       depth;
      bit                underflow;
      bit                overflow;
      bit                div_zero;
      rsp_type           pending_rsp [$];
      int unsigned       n_mismatch;

      function void push_operand(logic [DATA_W-1:0] v);
         if (depth >= STACK_DEPTH) begin
            overflow = 1'b1;
         end else begin
            operands[depth] = v;
            depth++;
         end
      endfunction

      function logic [DATA_W-1:0] pop_operand();
         if (depth == 0) begin
            underflow = 1'b1;
            return '1;
         end
         depth--;
         return operands[depth];
      endfunction

      function void take_request(req_type r);
         logic [DATA_W-1:0] lhs;
         logic [DATA_W-1:0] rhs;
         logic [DATA_W-1:0] res;
         rsp_type           want;
         if (r.finish) begin
            want.result_value        = pop_operand();
            want.underflow_seen      = underflow;
            want.overflow_seen       = overflow;
            want.divide_by_zero_seen = div_zero;
            pending_rsp.push_back(want);
            depth     = 0;
            underflow = 1'b0;
            overflow  = 1'b0;
            div_zero  = 1'b0;
         end else if (r.ch >= CH_ZERO && r.ch <= CH_NINE) begin
            push_operand(DATA_W'(r.ch - CH_ZERO));
         end else if (r.ch == CH_PLUS || r.ch == CH_MINUS ||
                      r.ch == CH_STAR || r.ch == CH_SLASH) begin
            rhs = pop_operand();
            lhs = pop_operand();
            case (r.ch)
               CH_PLUS:  res = lhs + rhs;
               CH_MINUS: res = lhs - rhs;
               CH_STAR:  res = lhs * rhs;
               default: begin
                  if (rhs == '0) begin
                     div_zero = 1'b1;
                     res      = '0;
                  end else if (lhs == MOST_NEG && rhs == '1) begin
                     res = MOST_NEG;
                  end else begin
                     res = $signed(lhs) / $signed(rhs);
                  end
               end
            endcase
            push_operand(res);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result: value %0d flags %b%b%b", $time,
                     got.result_value, got.underflow_seen, got.overflow_seen,
                     got.divide_by_zero_seen);
            n_mismatch++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.result_value !== want.result_value) begin
            $display("%0t: result_value expected %0d actual %0d", $time,
                     want.result_value, got.result_value);
            n_mismatch++;
         end
         if (got.underflow_seen !== want.underflow_seen) begin
            $display("%0t: underflow_seen expected %b actual %b", $time,
                     want.underflow_seen, got.underflow_seen);
            n_mismatch++;
         end
         if (got.overflow_seen !== want.overflow_seen) begin
            $display("%0t: overflow_seen expected %b actual %b", $time,
                     want.overflow_seen, got.overflow_seen);
            n_mismatch++;
         end
         if (got.divide_by_zero_seen !== want.divide_by_zero_seen) begin
            $display("%0t: divide_by_zero_seen expected %b actual %b", $time,
                     want.divide_by_zero_seen, got.divide_by_zero_seen);
            n_mismatch++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   postfix_tracker tracker = new();
   int unsigned    items_done;
   int unsigned    n_offered;
   bit             sender_busy;

   postfix_expression_evaluator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_op();
      case ($urandom_range(0, 3))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   task automatic send_request(logic [7:0] ch, logic fin);
      req_type r;
      r.ch     = ch;
      r.finish = fin;
      if (n_offered % 64 == 0)
         sender_busy = $urandom_range(0, 2) != 0;
      n_offered++;
      @(negedge clock);
      if (sender_busy && items_done < ITEM_TARGET - QUIET_ITEMS &&
          $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_request(r);
      if (fin || (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_PLUS ||
          ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH)
         items_done++;
   endtask

   task automatic send_char(logic [7:0] ch);
      send_request(ch, 1'b0);
   endtask

   task automatic send_finish();
      send_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_wellformed_expr();
      int unsigned pushes_left;
      int unsigned ops_left;
      int unsigned live;
      ops_left    = $urandom_range(0, 10);
      pushes_left = ops_left + 1;
      live        = 0;
      while (pushes_left > 0 || ops_left > 0) begin
         if ($urandom_range(0, 15) == 0)
            send_char(8'($urandom_range(0, 255)));
         if (live >= 2 && ops_left > 0 && (pushes_left == 0 || $urandom_range(0, 1))) begin
            send_char(rand_op());
            live--;
            ops_left--;
         end else begin
            send_char(rand_digit());
            live++;
            pushes_left--;
         end
      end
      send_finish();
   endtask

   task automatic send_broken_expr();
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 1))
            send_char(rand_digit());
         else
            send_char(rand_op());
      end
      send_finish();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1))
         send_finish();
   endtask

   task automatic send_product_chain();
      send_char(CH_NINE);
      repeat ($urandom_range(3, 12)) begin
         send_char(CH_ZERO + 8'($urandom_range(2, 9)));
         send_char(CH_STAR);
      end
      repeat ($urandom_range(0, 2)) begin
         send_char(rand_digit());
         send_char(rand_op());
      end
      send_finish();
   endtask

   // 8^10 * 2 wraps to the most negative value
   task automatic send_most_negative_expr();
      send_char(CH_ZERO + 8'd8);
      repeat (9) begin
         send_char(CH_ZERO + 8'd8);
         send_char(CH_STAR);
      end
      send_char(CH_ZERO + 8'd2);
      send_char(CH_STAR);
      if ($urandom_range(0, 2) != 0) begin
         send_char(CH_ZERO);
         send_char(CH_ZERO + 8'd1);
         send_char(CH_MINUS);
         send_char(CH_SLASH);
      end else begin
         send_char(rand_digit());
         send_char(rand_op());
      end
      send_finish();
   endtask

   task automatic send_overflow_expr();
      repeat (STACK_DEPTH + $urandom_range(1, 3)) send_char(rand_digit());
      repeat ($urandom_range(0, 4)) send_char(rand_op());
      send_finish();
   endtask

   // receiver: random stall bursts, one long hold to back up the block
   initial begin
      int unsigned burst_left;
      int unsigned phase_cycles;
      bit          busy;
      bit          hold_done;
      burst_left   = 0;
      phase_cycles = 0;
      busy         = 1'b1;
      hold_done    = 1'b0;
      rsp_stall    = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_cycles % 256 == 0)
            busy = $urandom_range(0, 2) != 0;
         phase_cycles++;
         if (!hold_done && items_done >= HOLD_AT) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         if (burst_left > 0) begin
            rsp_stall = 1'b1;
            burst_left--;
         end else if (busy && items_done < ITEM_TARGET - QUIET_ITEMS &&
                      $urandom_range(0, 9) == 0) begin
            rsp_stall  = 1'b1;
            burst_left = $urandom_range(0, 16);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_data);
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int unsigned seq_idx;
      int unsigned pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      items_done  = 0;
      n_offered   = 0;
      sender_busy = 1'b1;
      seq_idx     = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // terminator on an empty stack
      send_finish();
      // ignored character, then division by zero
      send_char(8'hFF);
      send_char(CH_NINE);
      send_char(CH_ZERO);
      send_char(CH_SLASH);
      send_finish();
      // subtraction and multiplication
      send_char(CH_ZERO + 8'd7);
      send_char(CH_ZERO + 8'd3);
      send_char(CH_MINUS);
      send_char(CH_NINE);
      send_char(CH_STAR);
      send_finish();
      // operator on an empty stack
      send_char(CH_PLUS);
      send_finish();
      // truncating division of a negative value
      send_char(CH_ZERO);
      send_char(CH_ZERO + 8'd7);
      send_char(CH_MINUS);
      send_char(CH_ZERO + 8'd2);
      send_char(CH_SLASH);
      send_finish();
      // terminator carrying a digit code
      send_char(CH_ZERO + 8'd5);
      send_request(CH_NINE, 1'b1);

      while (items_done < ITEM_TARGET) begin
         pick = (seq_idx < 6) ? seq_idx : $urandom_range(0, 39);
         seq_idx++;
         if (seq_idx <= 6) begin
            case (pick)
               0: send_wellformed_expr();
               1: send_broken_expr();
               2: send_noise();
               3: send_product_chain();
               4: send_most_negative_expr();
               default: send_overflow_expr();
            endcase
         end else if (pick < 26) begin
            send_wellformed_expr();
         end else if (pick < 31) begin
            send_broken_expr();
         end else if (pick < 35) begin
            send_noise();
         end else if (pick < 37) begin
            send_product_chain();
         end else if (pick < 39) begin
            send_most_negative_expr();
         end else begin
            send_overflow_expr();
         end
      end
      send_finish();

      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.n_mismatch == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
